FILE: hw/rtl/cce_pkg.sv
// Package for the configurable CRC engine: transaction types, register
// indexes and fixed field widths. No dependencies.
`default_nettype none

package cce_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcOutW  = 32;
  localparam int unsigned PolyW    = 33;
  localparam int unsigned CfgWidthW = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = PolyW;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegPoly  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b1;

  localparam logic [PolyW-1:0]     PolyRst  = 33'h0_0001_1021;
  localparam logic [CfgWidthW-1:0] WidthRst = 6'd16;

  // One input transaction as it travels from the input register to the core
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cce_item_t;

  // Config values shared with the core
  typedef struct packed {
    logic [PolyW-1:0]     poly;
    logic [CfgWidthW-1:0] width;
  } cce_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cce_in_reg.sv
// Input register stage of the CRC engine: holds one accepted byte until
// the core consumes it. Depends on cce_pkg.
`default_nettype none

module cce_in_reg import cce_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire cce_item_t item_i,
  input  wire logic      go_i,       // core consumes the held item this cycle
  output logic           vld_o,
  output cce_item_t      item_o
);

  logic      vld_q, vld_d;
  logic      load;
  cce_item_t item_q;

  assign in_stall_o = vld_q && !go_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (go_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cce_core.sv
// CRC core: running remainder register and the eight-bit MSB-first
// division step. Depends on cce_pkg.
`default_nettype none

module cce_core import cce_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire cce_item_t           item_i,
  input  wire cce_cfg_t            cfg_i,
  output logic                     done_o,
  output logic [CrcOutW-1:0]       crc_o
);

  localparam int unsigned EffW = $clog2(MAX_WIDTH + 1) > CfgWidthW ?
                                 $clog2(MAX_WIDTH + 1) : CfgWidthW + 1;
  localparam int unsigned IdxW = $clog2(MAX_WIDTH);
  localparam int unsigned ExtW = MAX_WIDTH + CrcOutW;

  logic [MAX_WIDTH-1:0] rem_q, rem_d;
  logic [EffW-1:0]      width_ext;
  logic [EffW-1:0]      eff_w;
  logic [EffW-1:0]      top_pos;
  logic [IdxW-1:0]      top_idx;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] poly;
  logic [MAX_WIDTH-1:0] r;
  logic [ExtW-1:0]      r_ext;
  logic                 fb;

  // Effective width: zero counts as one, saturates at MAX_WIDTH
  always_comb begin
    width_ext = EffW'(cfg_i.width);
    if (width_ext == '0) begin
      eff_w = EffW'(1);
    end else if (width_ext > EffW'(MAX_WIDTH)) begin
      eff_w = EffW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    top_pos = eff_w - EffW'(1);
    top_idx = top_pos[IdxW-1:0];
  end

  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      mask[k] = (EffW'(k) < eff_w);
    end
  end

  assign poly = MAX_WIDTH'(cfg_i.poly) & mask;

  // Eight unrolled shift-and-xor steps, MSB of the byte first
  always_comb begin
    r = rem_q & mask;
    fb = 1'b0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[top_idx] ^ item_i.data[i];
      r  = (r << 1) & mask;
      if (fb) begin
        r = r ^ poly;
      end
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (fire_i) begin
      rem_d = item_i.last ? '0 : r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign r_ext  = {{CrcOutW{1'b0}}, r};
  assign crc_o  = r_ext[CrcOutW-1:0];
  assign done_o = fire_i && item_i.last;

endmodule

`default_nettype wire

FILE: hw/rtl/cce_out_reg.sv
// Output register of the CRC engine: holds a finished CRC until the
// downstream side takes it. Depends on cce_pkg.
`default_nettype none

module cce_out_reg import cce_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [CrcOutW-1:0] crc_i,
  output logic                    free_o,   // can take a new result this cycle
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CrcOutW-1:0]      crc_value_o
);

  logic               vld_q, vld_d;
  logic [CrcOutW-1:0] crc_q;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      crc_q <= crc_i;
    end
  end

  assign out_valid_o = vld_q;
  assign crc_value_o = crc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/configurable_crc_engine.sv
// Top level of the configurable CRC engine: config registers, input
// register, CRC core and output register. Depends on cce_pkg, cce_in_reg,
// cce_core and cce_out_reg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | to block  | in_valid_i / in_stall_o | data_byte_i, last_byte_i
//   out     | from block| out_valid_o/ out_stall_i| crc_value_o
//   cfg     | to block  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One byte transaction per cycle sustained while no last byte is held back. A byte
// lands in the input register, the core folds it into the remainder register
// (eight unrolled xor steps), and on the last byte the CRC goes from the core into
// the output register and is valid there. Reset clears the remainder, both valid
// flags and loads the default CRC-16 polynomial 0x11021 at width 16. A stalled
// output holds only a last byte back; earlier bytes keep flowing into the remainder.
`default_nettype none

module configurable_crc_engine import cce_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Config write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input byte stream
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ByteW-1:0]    data_byte_i,
  input  wire logic                last_byte_i,
  // CRC results
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CrcOutW-1:0]       crc_value_o
);

  cce_cfg_t  cfg_q, cfg_d;
  cce_item_t in_item;
  cce_item_t s1_item;
  logic      s1_vld;
  logic      s1_go;
  logic      out_free;
  logic      done;
  logic [CrcOutW-1:0] crc;

  // Config registers; the user must write them only while the engine is idle, the block does not enforce it
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPoly:  cfg_d.poly  = cfg_data_i[PolyW-1:0];
        RegWidth: cfg_d.width = cfg_data_i[CfgWidthW-1:0];
        default:  cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly  <= PolyRst;
      cfg_q.width <= WidthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  // A held byte moves on unless it is a last byte facing a full output
  assign s1_go = s1_vld && (!s1_item.last || out_free);

  cce_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .go_i       (s1_go),
    .vld_o      (s1_vld),
    .item_o     (s1_item)
  );

  cce_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_go),
    .item_i (s1_item),
    .cfg_i  (cfg_q),
    .done_o (done),
    .crc_o  (crc)
  );

  cce_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (done),
    .crc_i       (crc),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o)
  );

endmodule

`default_nettype wire

FILE: verif/configurable_crc_engine_tb.sv
// Self-checking testbench for configurable_crc_engine: drives byte streams
// under random idling on both channels and checks every CRC against a model.
// Depends on cce_pkg and the configurable_crc_engine RTL.
`timescale 1ns / 100ps

module configurable_crc_engine_tb;
  import cce_pkg::*;

  localparam int unsigned MaxCrcW   = 32;
  localparam int unsigned ItemCount = 1850;
  // cycles to let the datapath settle after the last transaction
  localparam int unsigned IdleGap   = 5;

  // Tracks the running remainder and the CRC results still owed by the block.
  class crc_scoreboard;
    logic [PolyW-1:0]     poly;
    logic [CfgWidthW-1:0] width;
    logic [63:0]          remainder;
    logic [CrcOutW-1:0]   pending_crcs[$];
    int unsigned          errors;

    function new();
      poly      = PolyRst;
      width     = WidthRst;
      remainder = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegPoly: begin
          poly = data;
        end
        RegWidth: begin
          width = data[CfgWidthW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Fold one byte MSB first; a last byte closes the message and owes a CRC.
    function void accept_byte(cce_item_t item);
      int unsigned w;
      int          i;
      logic [63:0] mask;
      logic [63:0] gen;
      logic [63:0] r;
      logic        top;
      // zero width acts as 1, anything past the maximum saturates
      if (width == 0) w = 1;
      else if (width > MaxCrcW) w = MaxCrcW;
      else w = width;
      mask = (64'd1 << w) - 64'd1;
      gen  = {31'd0, poly} & mask;
      r    = remainder & mask;
      for (i = ByteW - 1; i >= 0; i--) begin
        top = r[w-1] ^ item.data[i];
        r   = (r << 1) & mask;
        if (top) r ^= gen;
      end
      if (item.last) begin
        pending_crcs.push_back(r[CrcOutW-1:0]);
        remainder = '0;
      end else begin
        remainder = r;
      end
    endfunction

    function void check_crc(logic [CrcOutW-1:0] actual);
      logic [CrcOutW-1:0] want;
      if (pending_crcs.size() == 0) begin
        $display("%0t: unexpected CRC, expected none, actual %h", $time, actual);
        errors++;
      end else begin
        want = pending_crcs.pop_front();
        if (want !== actual) begin
          $display("%0t: CRC mismatch, expected %h, actual %h", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [ByteW-1:0]     data_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CrcOutW-1:0]   crc_value;

  crc_scoreboard sb;
  bit            calm = 1'b0;   // no idling on either side while set
  int unsigned   bytes_sent = 0;

  configurable_crc_engine #(
    .MAX_WIDTH(MaxCrcW)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .crc_value_o (crc_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Everything is sampled on the edge with pre-edge values, like the DUT sees it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_data);
      if (in_valid && !in_stall) sb.accept_byte({data_byte, last_byte});
      if (out_valid && !out_stall) sb.check_crc(crc_value);
    end
  end

  // Result side: random stall before each transaction.
  initial begin
    int unsigned hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drain: stop sending, wait for every owed CRC, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_crcs.size() != 0) @(posedge clk);
    repeat (IdleGap) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    logic [CfgDataW-1:0]  wdata;
    logic [CfgDataW-1:0]  pdata;
    logic [CfgWidthW-1:0] w;
    int unsigned          pick;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = CfgWidthW'($urandom_range(MaxCrcW + 1, 63));
      2:       w = CfgWidthW'(MaxCrcW);
      3:       w = CfgWidthW'(1);
      default: w = CfgWidthW'($urandom_range(2, MaxCrcW - 1));
    endcase
    // upper bits of the width write are junk the block must ignore
    wdata = {1'($urandom_range(0, 1)), $urandom()};
    wdata[CfgWidthW-1:0] = w;
    case ($urandom_range(0, 9))
      0:       pdata = '0;
      1:       pdata = '1;
      default: pdata = {1'($urandom_range(0, 1)), $urandom()};
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      write_reg(RegPoly, pdata);
    end else if (pick == 1) begin
      write_reg(RegWidth, wdata);
    end else if (pick < 6) begin
      write_reg(RegPoly, pdata);
      write_reg(RegWidth, wdata);
    end else begin
      write_reg(RegWidth, wdata);
      write_reg(RegPoly, pdata);
    end
  endtask

  initial begin
    int unsigned      len;
    int unsigned      k;
    logic [ByteW-1:0] b;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset polynomial (CRC-16, width 16), extremes of the byte
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // check string "123456789"
    for (k = 0; k < 9; k++) send_byte(ByteW'(8'h31 + k), k == 8);
    wait_idle();

    // width zero behaves as width 1
    write_reg(RegPoly, 33'h0_0000_0003);
    write_reg(RegWidth, 33'd0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b1);
    wait_idle();

    // oversize width saturates to the maximum
    write_reg(RegPoly, 33'h1_04C1_1DB7);
    write_reg(RegWidth, 33'd63);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // full width with an all-ones generator
    write_reg(RegPoly, '1);
    write_reg(RegWidth, 33'd32);
    send_byte(8'h80, 1'b1);
    wait_idle();

    // width and polynomial change in the middle of a message
    write_reg(RegPoly, 33'h1_04C1_1DB7);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    wait_idle();
    write_reg(RegPoly, 33'h0_0000_0107);
    write_reg(RegWidth, 33'd8);
    send_byte(8'hBE, 1'b1);
    wait_idle();

    // CRC-7, then width 1 with an empty generator
    write_reg(RegPoly, 33'h0_0000_0089);
    write_reg(RegWidth, 33'd7);
    send_byte(8'h40, 1'b1);
    wait_idle();
    write_reg(RegPoly, 33'h0_0000_0002);
    write_reg(RegWidth, 33'd1);
    send_byte(8'h01, 1'b1);
    wait_idle();

    // Random phases: new settings, a batch of messages, then a full drain
    while (bytes_sent < ItemCount) begin
      calm = ($urandom_range(0, 3) == 0);
      random_config();
      repeat ($urandom_range(3, 12)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          b = ByteW'($urandom());
          send_byte(b, k == len - 1);
        end
      end
      // loose bytes with random last flags
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10)) begin
          b = ByteW'($urandom());
          send_byte(b, $urandom_range(0, 3) == 0);
        end
      end
      // leave a message open so the next settings apply mid-message
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          b = ByteW'($urandom());
          send_byte(b, 1'b0);
        end
      end
      wait_idle();
    end

    calm = 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cce_pkg.sv
hw/rtl/cce_in_reg.sv
hw/rtl/cce_core.sv
hw/rtl/cce_out_reg.sv
hw/rtl/configurable_crc_engine.sv
verif/configurable_crc_engine_tb.sv
